FILE: hdl/fcf_pkg.sv
// Package for field_comb_factor: shared widths, limits and the line-job type.
// No dependencies.
package fcf_pkg;

    localparam int LUMA_W   = 8;
    localparam int TERM_W   = 18;
    localparam int ENERGY_W = 29;
    localparam int SQRT_W   = 15;
    localparam int ROOT_W   = 14;
    localparam int TOTAL_W  = 23;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
    localparam logic [ROOT_W-1:0]   ROOT_MAX   = {ROOT_W{1'b1}};
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                eof;
    } line_job_t;

endpackage

FILE: hdl/fcf_front.sv
// Front end: accepts pixel transactions, squares the second difference and
// accumulates it per line; emits a line job at each line end. Uses fcf_pkg.
module fcf_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [fcf_pkg::LUMA_W-1:0] luma_upper,
    input  logic [fcf_pkg::LUMA_W-1:0] luma_middle,
    input  logic [fcf_pkg::LUMA_W-1:0] luma_lower,
    input  logic                      end_of_line,
    input  logic                      end_of_frame,
    input  logic                      push,
    output logic                      full,
    input  logic                      q_full,
    output logic                      job_push,
    output fcf_pkg::line_job_t        job
);
    import fcf_pkg::*;

    logic                    s1_valid_reg;
    logic                    s1_eol_reg;
    logic                    s1_eof_reg;
    logic [TERM_W-1:0]       term_reg;
    logic [ENERGY_W-1:0]     energy_reg;
    logic                    stall;
    logic                    accept;
    logic signed [10:0]      diff;
    logic [8:0]              diff_abs;
    logic [TERM_W-1:0]       term_next;
    logic [ENERGY_W:0]       energy_sum;
    logic [ENERGY_W-1:0]     energy_sat;

    assign stall  = s1_valid_reg && s1_eol_reg && q_full;
    assign full   = stall;
    assign accept = push && !stall;

    always_comb
    begin
        diff = $signed({3'b000, luma_upper}) + $signed({3'b000, luma_lower})
             - $signed({2'b00, luma_middle, 1'b0});
        if (diff < 0)
            diff_abs = 9'(-diff);
        else
            diff_abs = diff[8:0];
        term_next = diff_abs * diff_abs;
    end

    assign energy_sum = {1'b0, energy_reg} + {{(ENERGY_W+1-TERM_W){1'b0}}, term_reg};
    assign energy_sat = energy_sum[ENERGY_W] ? ENERGY_MAX : energy_sum[ENERGY_W-1:0];

    assign job_push   = s1_valid_reg && s1_eol_reg && !q_full;
    assign job.energy = energy_sat;
    assign job.eof    = s1_eof_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_eol_reg   <= 1'b0;
            s1_eof_reg   <= 1'b0;
            term_reg     <= '0;
            energy_reg   <= '0;
        end
        else if (!stall)
        begin
            s1_valid_reg <= accept;
            s1_eol_reg   <= end_of_line || end_of_frame;
            s1_eof_reg   <= end_of_frame;
            term_reg     <= term_next;
            if (s1_valid_reg)
                energy_reg <= s1_eol_reg ? '0 : energy_sat;
        end
    end

endmodule

FILE: hdl/fcf_fifo.sv
// Short queue of line jobs between front and back ends. Uses fcf_pkg.
module fcf_fifo #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fcf_pkg::line_job_t push_data,
    output logic               full,
    input  logic               pop,
    output fcf_pkg::line_job_t pop_data,
    output logic               empty
);
    import fcf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    line_job_t          mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop && !empty)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            if ((push && !full) && !(pop && !empty))
                count_reg <= count_reg + 1'b1;
            else if (!(push && !full) && (pop && !empty))
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: hdl/fcf_back.sv
// Back end: bit-serial floor square root of each line sum, saturating frame
// total, and the result register. Uses fcf_pkg.
module fcf_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fcf_pkg::line_job_t          job,
    input  logic                        job_valid,
    output logic                        job_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [fcf_pkg::ROOT_W-1:0]  line_root,
    output logic [fcf_pkg::TOTAL_W-1:0] comb_total,
    output logic                        frame_done
);
    import fcf_pkg::*;

    localparam int VAL_W = 2 * SQRT_W;
    localparam int REM_W = SQRT_W + 2;
    localparam int CNT_W = $clog2(SQRT_W);
    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(SQRT_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_ADD
    } state_t;

    state_t               state_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [SQRT_W-1:0]    root_reg;
    logic [CNT_W-1:0]     iter_reg;
    logic                 eof_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic                 out_valid_reg;
    logic [ROOT_W-1:0]    out_root_reg;
    logic [TOTAL_W-1:0]   out_total_reg;
    logic                 out_eof_reg;

    logic [REM_W+1:0]     rem_try;
    logic [REM_W+1:0]     trial;
    logic                 take;
    logic [ROOT_W-1:0]    root_sat;
    logic [TOTAL_W:0]     total_sum;
    logic [TOTAL_W-1:0]   total_sat;
    logic                 slot_free;

    always_comb
    begin
        rem_try   = {rem_reg, val_reg[VAL_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        take      = (rem_try >= trial);
        root_sat  = (root_reg > {1'b0, ROOT_MAX}) ? ROOT_MAX : root_reg[ROOT_W-1:0];
        total_sum = {1'b0, total_reg} + {{(TOTAL_W+1-ROOT_W){1'b0}}, root_sat};
        total_sat = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
        slot_free = !out_valid_reg || pop;
    end

    assign job_pop    = (state_reg == ST_IDLE) && job_valid;
    assign empty      = !out_valid_reg;
    assign line_root  = out_root_reg;
    assign comb_total = out_total_reg;
    assign frame_done = out_eof_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            val_reg       <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            iter_reg      <= '0;
            eof_reg       <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_root_reg  <= '0;
            out_total_reg <= '0;
            out_eof_reg   <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg && !((state_reg == ST_ADD) && slot_free))
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        val_reg   <= {{(VAL_W-ENERGY_W){1'b0}}, job.energy};
                        eof_reg   <= job.eof;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        iter_reg  <= '0;
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    val_reg  <= {val_reg[VAL_W-3:0], 2'b00};
                    root_reg <= {root_reg[SQRT_W-2:0], take};
                    if (take)
                        rem_reg <= REM_W'(rem_try - trial);
                    else
                        rem_reg <= rem_try[REM_W-1:0];
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_LAST)
                        state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_root_reg  <= root_sat;
                        out_total_reg <= total_sat;
                        out_eof_reg   <= eof_reg;
                        total_reg     <= eof_reg ? '0 : total_sat;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/field_comb_factor.sv
// Top level of the interlace comb-factor measure: front end, line-job queue
// and square-root back end. Uses fcf_pkg, fcf_front, fcf_fifo, fcf_back.
//
// Pixel transactions are taken one per clock while full is low; each pixel's
// squared term is registered and then added into the line accumulator. At a
// line end (end_of_line or end_of_frame) the line sum is queued for the back
// end, whose bit-serial square root loads the sum, runs 15 root steps, then
// updates the total and output register. LINE_QUEUE_DEPTH line sums can wait
// in the queue; full rises only while a line end meets a full queue. One
// result transaction per line is held in an output register until popped;
// frame_done marks the last line of a frame, after which the frame total
// restarts from zero.
module field_comb_factor #(
    parameter int LINE_QUEUE_DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [fcf_pkg::LUMA_W-1:0]  luma_upper,
    input  logic [fcf_pkg::LUMA_W-1:0]  luma_middle,
    input  logic [fcf_pkg::LUMA_W-1:0]  luma_lower,
    input  logic                        end_of_line,
    input  logic                        end_of_frame,
    output logic                        empty,
    input  logic                        pop,
    output logic [fcf_pkg::ROOT_W-1:0]  line_root,
    output logic [fcf_pkg::TOTAL_W-1:0] comb_total,
    output logic                        frame_done
);
    import fcf_pkg::*;

    line_job_t job_in;
    line_job_t job_out;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;

    fcf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .luma_upper   (luma_upper),
        .luma_middle  (luma_middle),
        .luma_lower   (luma_lower),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame),
        .push         (push),
        .full         (full),
        .q_full       (q_full),
        .job_push     (q_push),
        .job          (job_in)
    );

    fcf_fifo #(
        .DEPTH (LINE_QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (job_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (job_out),
        .empty     (q_empty)
    );

    fcf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (job_out),
        .job_valid  (!q_empty),
        .job_pop    (q_pop),
        .pop        (pop),
        .empty      (empty),
        .line_root  (line_root),
        .comb_total (comb_total),
        .frame_done (frame_done)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("line queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("line queue read while empty");

    a_total_covers_root: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ({1'b0, comb_total} >= {{(TOTAL_W+1-ROOT_W){1'b0}}, line_root}))
        else $error("frame total below line root");
`endif

endmodule

FILE: sim/tb_field_comb_factor.sv
`timescale 1ns / 1ps
// Testbench for field_comb_factor: drives pixel transactions with random gaps and
// stalls and checks every line result against an in-bench predictor.
// Depends on fcf_pkg and the field_comb_factor RTL.
module tb_field_comb_factor;
    import fcf_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [ROOT_W-1:0]  root;
        logic [TOTAL_W-1:0] total;
        logic               done;
    } line_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [LUMA_W-1:0] luma_upper = '0;
    logic [LUMA_W-1:0] luma_middle = '0;
    logic [LUMA_W-1:0] luma_lower = '0;
    logic              end_of_line = 1'b0;
    logic              end_of_frame = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic [ROOT_W-1:0]  line_root;
    logic [TOTAL_W-1:0] comb_total;
    logic               frame_done;

    logic [ENERGY_W-1:0] pred_energy = '0;
    logic [TOTAL_W-1:0]  pred_total = '0;
    line_result_t        pending_lines[$];
    line_result_t        want;
    bit                  idle_on = 1'b1;
    int                  hold_cycles = 0;
    int                  fail_count = 0;
    int                  cycle_count = 0;

    field_comb_factor DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .luma_upper   (luma_upper),
        .luma_middle  (luma_middle),
        .luma_lower   (luma_lower),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame),
        .empty        (empty),
        .pop          (pop),
        .line_root    (line_root),
        .comb_total   (comb_total),
        .frame_done   (frame_done)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            c = r | (longint'(1) << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic void accumulate_pixel(input logic [LUMA_W-1:0] u, m, l,
                                             input logic eol, eof);
        int           d;
        longint       sum;
        longint       root;
        line_result_t res;
        d = int'(u) + int'(l) - 2 * int'(m);
        sum = longint'(pred_energy) + longint'(d * d);
        pred_energy = (sum > ENERGY_MAX) ? ENERGY_MAX : sum[ENERGY_W-1:0];
        if (!(eol || eof))
            return;
        root = longint'(floor_root(pred_energy));
        if (root > ROOT_MAX)
            root = ROOT_MAX;
        pred_energy = '0;
        sum = longint'(pred_total) + root;
        pred_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        res.root = root[ROOT_W-1:0];
        res.total = pred_total;
        res.done = eof;
        pending_lines.push_back(res);
        if (eof)
            pred_total = '0;
    endfunction

    function automatic void check_field(input string name, input longint unsigned exp_val,
                                        input logic [31:0] got);
        if (got !== exp_val[31:0])
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, got);
            fail_count++;
        end
    endfunction

    task automatic send_pixel(input logic [LUMA_W-1:0] u, m, l, input logic eol, eof);
        int gap;
        push         <= 1'b1;
        luma_upper   <= u;
        luma_middle  <= m;
        luma_lower   <= l;
        end_of_line  <= eol;
        end_of_frame <= eof;
        @(posedge clk);
        while (full)
            @(posedge clk);
        accumulate_pixel(u, m, l, eol, eof);
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side: check the transaction taken at this edge, then choose pop
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_lines.size() == 0)
                begin
                    $error("result with none pending: line_root %0d comb_total %0d frame_done %0d",
                           line_root, comb_total, frame_done);
                    fail_count++;
                end
                else
                begin
                    want = pending_lines.pop_front();
                    check_field("line_root", want.root, 32'(line_root));
                    check_field("comb_total", want.total, 32'(comb_total));
                    check_field("frame_done", want.done, 32'(frame_done));
                end
            end
            if (hold_cycles > 0)
            begin
                pop <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                pop <= 1'b1;
                hold_cycles = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_field_comb_factor failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b1, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b1, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd1, 8'd128, 8'd254, 1'b1, 1'b0);
        send_pixel(8'd128, 8'd127, 8'd128, 1'b0, 1'b0);
        // frame end with end_of_line low still closes the line
        send_pixel(8'd0, 8'd255, 8'd255, 1'b0, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b1, 1'b1);
        send_pixel(8'd170, 8'd85, 8'd85, 1'b1, 1'b1);
        send_pixel(8'd85, 8'd170, 8'd170, 1'b0, 1'b0);
        send_pixel(8'd254, 8'd1, 8'd127, 1'b1, 1'b0);
        send_pixel(8'd3, 8'd0, 8'd0, 1'b0, 1'b1);
    endtask

    // line long enough to clip the root but not the line energy
    task automatic test_root_saturation();
        for (int px = 0; px < 1040; px++)
            send_pixel(8'd255, 8'd0, 8'd255, px == 1039, 1'b0);
        send_pixel(8'd0, 8'd100, 8'd0, 1'b1, 1'b1);
    endtask

    task automatic test_random_frames();
        int                sent;
        int                n_lines;
        int                len;
        int                style;
        int                base;
        int                hi;
        int                lo;
        logic [LUMA_W-1:0] u;
        logic [LUMA_W-1:0] m;
        logic [LUMA_W-1:0] l;
        logic              eol;
        logic              eof;
        sent = 0;
        while (sent < 900)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            n_lines = $urandom_range(1, 8);
            for (int ln = 0; ln < n_lines; ln++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300)
                                                  : $urandom_range(1, 24);
                style = $urandom_range(0, 3);
                for (int px = 0; px < len; px++)
                begin
                    case (style)
                        0:
                        begin
                            u = 8'($urandom_range(0, 255));
                            m = 8'($urandom_range(0, 255));
                            l = 8'($urandom_range(0, 255));
                        end
                        1:
                        begin
                            u = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                            m = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                            l = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                        end
                        2:
                        begin
                            base = $urandom_range(4, 251);
                            u = 8'(base - 2 + $urandom_range(0, 4));
                            m = 8'(base - 2 + $urandom_range(0, 4));
                            l = 8'(base - 2 + $urandom_range(0, 4));
                        end
                        default:
                        begin
                            hi = $urandom_range(180, 255);
                            lo = $urandom_range(0, 70);
                            if ($urandom_range(0, 1))
                            begin
                                u = 8'(hi);
                                l = 8'(hi - $urandom_range(0, 20));
                                m = 8'(lo);
                            end
                            else
                            begin
                                u = 8'(lo);
                                l = 8'(lo + $urandom_range(0, 20));
                                m = 8'(hi);
                            end
                        end
                    endcase
                    eol = (px == len - 1);
                    eof = eol && (ln == n_lines - 1);
                    if (eof && $urandom_range(0, 1))
                        eol = 1'b0;
                    // stray markers inside a line
                    if (!eol && !eof && $urandom_range(0, 49) == 0)
                    begin
                        eol = 1'($urandom_range(0, 1));
                        eof = !eol || $urandom_range(0, 1);
                    end
                    send_pixel(u, m, l, eol, eof);
                    sent++;
                end
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_root_saturation();
        test_random_frames();
        push <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("tb_field_comb_factor passed");
        else
            $display("tb_field_comb_factor failed");
        $finish;
    end

endmodule
